[sv/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication or plain property checked on every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[sv/mf3_pkg.sv]
package mf3_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int MIN_SIZE  = 3;
    localparam int CFG_RESET = 1024;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // per-item side information carried down the median pipe
    typedef struct packed {
        logic   emit;
        logic   done;
        t_coord crow;
        t_coord ccol;
    } t_meta;

    // one new window column plus its side information
    typedef struct packed {
        t_pix  top;
        t_pix  mid;
        t_pix  bot;
        t_meta meta;
    } t_col_item;

    // a column sorted ascending
    typedef struct packed {
        t_pix lo;
        t_pix md;
        t_pix hi;
    } t_sorted;

endpackage

[sv/mf3_ifs.sv]
interface mf3_pix_if;
    import mf3_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel;
    logic frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface mf3_med_if;
    import mf3_pkg::*;

    logic   valid;
    logic   ready;
    t_pix   median;
    t_coord center_row;
    t_coord center_col;
    logic   frame_done;

    modport source (output valid, output median, output center_row, output center_col,
                    output frame_done, input ready);
    modport sink   (input valid, input median, input center_row, input center_col,
                    input frame_done, output ready);
endinterface

[sv/mf3_ram.sv]
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/mf3_line_stage.sv]
`include "assert_macros.svh"

module mf3_line_stage #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  mf3_pkg::t_pix                  i_pixel,
    input  logic                           i_frame_start,
    input  logic [$clog2(MAX_WIDTH):0]     i_width,
    input  logic [$clog2(MAX_HEIGHT):0]    i_height,
    output logic                           o_valid,
    input  logic                           i_ready,
    output mf3_pkg::t_col_item             o_col
);
    import mf3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = CW + 1;
    localparam int HW = RW + 1;
    localparam int LW = 2 * PIX_W;

    logic [CW-1:0] r_col, n_col, cur_c;
    logic [RW-1:0] r_row, n_row, cur_r;
    logic [EW-1:0] col_inc;
    logic [HW-1:0] row_inc;

    logic          r_a_valid;
    t_pix          r_a_px;
    logic [CW-1:0] r_a_c;
    logic [RW-1:0] r_a_r;
    logic          r_fwd;
    logic [LW-1:0] r_fwd_data;

    logic          acc, a_go, a_free;
    logic [LW-1:0] ram_rdata, line_pair;
    t_pix          a_up, a_mid;

    assign a_go   = r_a_valid && i_ready;
    assign a_free = !r_a_valid || i_ready;
    assign acc    = i_valid && a_free;
    assign o_ready = a_free;

    // position of the incoming pixel and of the one after it
    always_comb begin
        cur_c   = i_frame_start ? '0 : r_col;
        cur_r   = i_frame_start ? '0 : r_row;
        col_inc = {1'b0, cur_c} + EW'(1);
        row_inc = {1'b0, cur_r} + HW'(1);
        n_col   = col_inc[CW-1:0];
        n_row   = cur_r;
        if (col_inc >= i_width) begin
            n_col = '0;
            n_row = (row_inc >= i_height) ? '0 : row_inc[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // same column read and written back on one edge: take the write data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (acc) begin
                r_a_valid <= 1'b1;
                r_fwd     <= a_go && (r_a_c == cur_c);
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_px     <= i_pixel;
            r_a_c      <= cur_c;
            r_a_r      <= cur_r;
            r_fwd_data <= line_pair;
        end
    end

    assign a_up      = r_fwd ? r_fwd_data[LW-1:PIX_W] : ram_rdata[LW-1:PIX_W];
    assign a_mid     = r_fwd ? r_fwd_data[PIX_W-1:0]  : ram_rdata[PIX_W-1:0];
    assign line_pair = {a_mid, r_a_px};

    // upper line in the high byte, middle line in the low byte
    mf3_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_c),
        .i_wdata (line_pair),
        .i_re    (acc),
        .i_raddr (cur_c),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_col.top       = a_up;
        o_col.mid       = a_mid;
        o_col.bot       = r_a_px;
        o_col.meta.emit = (r_a_r >= RW'(2)) && (r_a_c >= CW'(2));
        o_col.meta.done = (({1'b0, r_a_r} + HW'(1)) == i_height)
                       && (({1'b0, r_a_c} + EW'(1)) == i_width);
        o_col.meta.crow = COORD_W'(r_a_r - RW'(1));
        o_col.meta.ccol = COORD_W'(r_a_c - CW'(1));
    end

    assign o_valid = r_a_valid;

    `ASSERT_AT(a_rdata_held, i_clk, i_rst_n, r_a_valid && !i_ready |=> $stable(ram_rdata))
    `ASSERT_AT(a_acc_loads, i_clk, i_rst_n, acc |=> r_a_valid)
endmodule

[sv/mf3_median.sv]
`include "assert_macros.svh"

module mf3_median (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mf3_pkg::t_col_item i_col,
    mf3_med_if.source          o_med
);
    import mf3_pkg::*;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_sorted sort3(input t_pix a, input t_pix b, input t_pix c);
        t_sorted s;
        s.lo = min2(min2(a, b), c);
        s.hi = max2(max2(a, b), c);
        s.md = med3(a, b, c);
        return s;
    endfunction

    logic      r_b_valid;
    t_col_item r_b;
    logic      r_c_valid;
    t_meta     r_c_meta;
    t_sorted   r_win [3];
    logic      r_d_valid;
    t_meta     r_d_meta;
    t_pix      r_d_lo, r_d_md, r_d_hi;
    logic      r_o_valid;
    t_pix      r_o_med;
    t_meta     r_o_meta;

    logic b_go, b_free, c_go, c_free, d_go, d_free, o_free;

    assign o_free = !r_o_valid || o_med.ready;
    assign d_go   = r_d_valid && (!r_d_meta.emit || o_free);
    assign d_free = !r_d_valid || d_go;
    assign c_go   = r_c_valid && d_free;
    assign c_free = !r_c_valid || c_go;
    assign b_go   = r_b_valid && c_free;
    assign b_free = !r_b_valid || b_go;
    assign o_ready = b_free;

    // valids of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_valid && b_free) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go) begin
                r_c_valid <= 1'b1;
            end else if (c_go) begin
                r_c_valid <= 1'b0;
            end
            if (c_go) begin
                r_d_valid <= 1'b1;
            end else if (d_go) begin
                r_d_valid <= 1'b0;
            end
            if (d_go && r_d_meta.emit) begin
                r_o_valid <= 1'b1;
            end else if (o_med.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // window of sorted columns, oldest in slot 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= '0;
            end
        end else if (b_go) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= sort3(r_b.top, r_b.mid, r_b.bot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && b_free) begin
            r_b <= i_col;
        end
        if (b_go) begin
            r_c_meta <= r_b.meta;
        end
        // max of lows, median of mids, min of highs
        if (c_go) begin
            r_d_meta <= r_c_meta;
            r_d_lo   <= max2(max2(r_win[0].lo, r_win[1].lo), r_win[2].lo);
            r_d_md   <= med3(r_win[0].md, r_win[1].md, r_win[2].md);
            r_d_hi   <= min2(min2(r_win[0].hi, r_win[1].hi), r_win[2].hi);
        end
        if (d_go && r_d_meta.emit) begin
            r_o_med  <= med3(r_d_lo, r_d_md, r_d_hi);
            r_o_meta <= r_d_meta;
        end
    end

    assign o_med.valid      = r_o_valid;
    assign o_med.median     = r_o_med;
    assign o_med.center_row = r_o_meta.crow;
    assign o_med.center_col = r_o_meta.ccol;
    assign o_med.frame_done = r_o_meta.done;

    `ASSERT_AT(d_held_when_out_full, i_clk, i_rst_n,
        r_d_valid && r_d_meta.emit && !o_free |=> r_d_valid)
    `ASSERT_AT(b_moves_to_c, i_clk, i_rst_n, b_go |=> r_c_valid)
endmodule

[sv/median_filter_3x3_unit.sv]
// 3x3 median filter, one gray pixel in per cycle, one median per interior pixel
// throughput: 1 item per cycle while the median output is not back-pressured,
// set by the single read-modify-write of the line ram
// reset (i_rst_n low at a clock edge): position counters, pipeline valids and the
// window clear, size registers return to 1024; line ram contents are not cleared
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mf3_pix_if.sink                      i_pix,
    mf3_med_if.source                    o_med,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mf3_pkg::APB_AW-1:0]   paddr,
    input  logic [mf3_pkg::APB_DW-1:0]   pwdata,
    output logic [mf3_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import mf3_pkg::*;

    localparam int EW = $clog2(MAX_WIDTH) + 1;
    localparam int HW = $clog2(MAX_HEIGHT) + 1;

    // raw size registers as written
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    // sizes saturated into 3..MAX
    logic [EW-1:0]    width_eff;
    logic [HW-1:0]    height_eff;
    t_reg_idx         reg_sel;

    logic      line_valid, line_ready, line_in_ready;
    t_col_item line_col;

    assign reg_sel = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    // apb write: register taken at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(CFG_RESET);
            r_cfg_height <= CFG_W'(CFG_RESET);
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  r_cfg_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // apb read mux
    always_comb begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg_height);
            default:          prdata = '0;
        endcase
    end

    // saturate sizes so the counters never run past the line ram
    always_comb begin
        if (r_cfg_width < CFG_W'(MIN_SIZE)) begin
            width_eff = EW'(MIN_SIZE);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = EW'(r_cfg_width);
        end
        if (r_cfg_height < CFG_W'(MIN_SIZE)) begin
            height_eff = HW'(MIN_SIZE);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(r_cfg_height);
        end
    end

    // position tracking and line ram: yields one new window column per item
    mf3_line_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_pix.valid),
        .o_ready       (line_in_ready),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_width       (width_eff),
        .i_height      (height_eff),
        .o_valid       (line_valid),
        .i_ready       (line_ready),
        .o_col         (line_col)
    );

    assign i_pix.ready = line_in_ready;

    // column sort, window, median network and output register
    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (line_valid),
        .o_ready (line_ready),
        .i_col   (line_col),
        .o_med   (o_med)
    );
endmodule

[bench/tb_median_filter_3x3_unit.sv]
module tb_median_filter_3x3_unit;
    import mf3_pkg::*;

    localparam int LINE_MAX    = 1024;   // matches the block's default MAX_WIDTH / MAX_HEIGHT
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 360;
    localparam int SETTLE      = 8;      // margin for the pipeline registers to empty after the last input

    // how the pixel values of a stretch of stimulus are drawn
    typedef enum int {
        PIX_ANY,      // full 8-bit range
        PIX_BINARY,   // only black and white, lots of equal values
        PIX_TIES      // four neighboring grays, heavy ties in the sort
    } pix_mode_e;

    // one median the block owes us
    typedef struct {
        t_pix   median;
        t_coord center_row;
        t_coord center_col;
        logic   frame_done;
    } median_item;

    // predictor of the filter plus the queue of medians still to come
    class median_board;
        t_pix        upper_row [LINE_MAX];
        t_pix        middle_row[LINE_MAX];
        t_pix        win[9];
        int unsigned row;
        int unsigned col;
        int unsigned width;
        int unsigned height;
        median_item  medians_due[$];
        int          mismatches;

        function new();
            foreach (win[i]) win[i] = '0;
            row = 0;
            col = 0;
            width = CFG_RESET;
            height = CFG_RESET;
            mismatches = 0;
        endfunction

        // sizes are used saturated to 3..LINE_MAX
        function int unsigned fit(int unsigned v);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > LINE_MAX) return LINE_MAX;
            return v;
        endfunction

        function int unsigned line_len();
            return fit(width);
        endfunction

        function bit at_origin();
            return row == 0 && col == 0;
        endfunction

        function int pending();
            return medians_due.size();
        endfunction

        function void set_size(t_reg_idx idx, logic [CFG_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) width = val;
            else height = val;
        endfunction

        // plain sort of the nine window values, the fifth one is the median
        function t_pix mid_of_nine();
            t_pix s[9];
            t_pix t;
            int   j;
            foreach (win[i]) s[i] = win[i];
            for (int i = 1; i < 9; i++) begin
                t = s[i];
                j = i - 1;
                while (j >= 0 && s[j] > t) begin
                    s[j+1] = s[j];
                    j--;
                end
                s[j+1] = t;
            end
            return s[4];
        endfunction

        function void note_pixel(t_pix px, logic fs);
            int unsigned w, h, r, c;
            t_pix        up, mid;
            median_item  e;
            w = fit(width);
            h = fit(height);
            if (fs) begin
                row = 0;
                col = 0;
            end
            r = row;
            c = col;
            // line stores shift down by one row at this column
            up = upper_row[c];
            mid = middle_row[c];
            upper_row[c] = mid;
            middle_row[c] = px;
            for (int i = 0; i < 6; i++) win[i] = win[i+3];
            win[6] = up;
            win[7] = mid;
            win[8] = px;
            if (r >= 2 && c >= 2) begin
                e.median = mid_of_nine();
                e.center_row = t_coord'(r - 1);
                e.center_col = t_coord'(c - 1);
                e.frame_done = (r == h - 1) && (c == w - 1);
                medians_due.push_back(e);
            end
            // raster advance, past the end wraps into the next frame
            c = col + 1;
            if (c >= w) begin
                c = 0;
                r = row + 1;
                if (r >= h) r = 0;
                row = r;
            end
            col = c;
        endfunction

        function void check_median(t_pix m, t_coord cr, t_coord cc, logic fd);
            median_item e;
            if (medians_due.size() == 0) begin
                $error("unexpected median item: median %0d row %0d col %0d", m, cr, cc);
                mismatches++;
                return;
            end
            e = medians_due.pop_front();
            if (m !== e.median) begin
                $error("median: expected %0d, got %0d", e.median, m);
                mismatches++;
            end
            if (cr !== e.center_row) begin
                $error("center_row: expected %0d, got %0d", e.center_row, cr);
                mismatches++;
            end
            if (cc !== e.center_col) begin
                $error("center_col: expected %0d, got %0d", e.center_col, cc);
                mismatches++;
            end
            if (fd !== e.frame_done) begin
                $error("frame_done: expected %0d, got %0d", e.frame_done, fd);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    // apb side
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    mf3_pix_if pix_if ();
    mf3_med_if med_if ();

    median_board board = new();

    bit          calm;          // when set neither side idles
    int unsigned cycles;
    int          random_sent;

    median_filter_3x3_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_med   (med_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // random idle decision, taken with a chance of roughly 35 percent
    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 35);
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("median_filter_3x3_unit: mismatch");
            $finish;
        end
    end

    // result side: random back-pressure, every accepted item goes to the board
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            med_if.ready <= 1'b0;
        end else begin
            med_if.ready <= !idle_roll();
            if (med_if.valid && med_if.ready)
                board.check_median(med_if.median, med_if.center_row, med_if.center_col,
                                   med_if.frame_done);
        end
    end

    // one pixel item, with random gaps before it
    task automatic push_pixel(input t_pix px, input logic fs);
        while (idle_roll()) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        pix_if.frame_start <= fs;
        do @(posedge i_clk); while (!pix_if.ready);
        board.note_pixel(px, fs);
    endtask

    // stop sending, let every median come out, then give the pipe time to empty
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic read_reg(input t_reg_idx idx, input logic [CFG_W-1:0] want);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(want)) begin
            $error("register %s: expected %0d, got %0d", idx.name(), want, prdata);
            board.mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one size register and read it back
    task automatic set_size(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_size(idx, val);
        read_reg(idx, val);
    endtask

    // a run of pixels; restart forces a frame start on the first one,
    // noisy adds the odd frame start in the middle of a frame
    task automatic stream_pixels(input int n, input bit restart, input bit noisy,
                                 input pix_mode_e mode);
        t_pix px;
        logic fs;
        for (int k = 0; k < n; k++) begin
            if (k == 0 && restart) fs = 1'b1;
            else if (board.at_origin()) fs = $urandom_range(1);
            else fs = noisy && ($urandom_range(99) < 4);
            case (mode)
                PIX_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
                PIX_TIES:   px = t_pix'(100 + $urandom_range(3));
                default:    px = t_pix'($urandom_range(255));
            endcase
            push_pixel(px, fs);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] new_w, new_h;
        int unsigned      old_len;
        bit               grew;
        int               n;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        pix_if.frame_start = 1'b0;
        med_if.ready = 1'b0;
        cycles = 0;
        calm = 1'b0;
        random_sent = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sizes come up at their reset values
        read_reg(REG_IMAGE_WIDTH, CFG_W'(CFG_RESET));
        read_reg(REG_IMAGE_HEIGHT, CFG_W'(CFG_RESET));

        // directed: a 5x4 frame of 00/55/aa/ff, then wrap into the next frame
        set_size(REG_IMAGE_WIDTH, 11'd5);
        set_size(REG_IMAGE_HEIGHT, 11'd4);
        for (int i = 0; i < 24; i++)
            push_pixel({4{2'(i)}}, i == 0);
        drain();
        // shrink the width while the position is past the new right edge
        set_size(REG_IMAGE_WIDTH, 11'd3);
        push_pixel(8'h80, 1'b0);
        push_pixel(8'h7F, 1'b1);    // restart at the start of a row, mid-frame
        drain();

        // widest frame, three rows high: the start of its top row only
        set_size(REG_IMAGE_WIDTH, 11'h7FF);
        set_size(REG_IMAGE_HEIGHT, 11'd0);
        stream_pixels(LINE_MAX / 8, 1'b1, 1'b0, PIX_ANY);
        drain();

        // tallest frame, narrowest width, no idling on either side
        calm = 1'b1;
        set_size(REG_IMAGE_WIDTH, 11'd2);
        set_size(REG_IMAGE_HEIGHT, 11'd1024);
        stream_pixels(180, 1'b1, 1'b0, PIX_TIES);
        drain();
        calm = 1'b0;

        // random phases, sizes change between phases, often mid-frame
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       new_w = $urandom_range(2);
                9:       new_w = $urandom_range(40, 13);
                default: new_w = $urandom_range(12, 3);
            endcase
            case ($urandom_range(9))
                0:       new_h = $urandom_range(2);
                1:       new_h = 11'h7FF;
                2:       new_h = $urandom_range(1500, 1000);
                default: new_h = $urandom_range(9, 3);
            endcase
            old_len = board.line_len();
            case ($urandom_range(3))
                0: set_size(REG_IMAGE_WIDTH, new_w);
                1: set_size(REG_IMAGE_HEIGHT, new_h);
                default: begin
                    set_size(REG_IMAGE_WIDTH, new_w);
                    set_size(REG_IMAGE_HEIGHT, new_h);
                end
            endcase
            // a wider line mid-frame would read line store entries never written,
            // so a grown width always begins a fresh frame
            grew = board.line_len() > old_len;
            n = $urandom_range(110, 30);
            stream_pixels(n, grew, 1'b1, pix_mode_e'($urandom_range(2)));
            random_sent += n;
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("median_filter_3x3_unit: match");
        else
            $display("median_filter_3x3_unit: mismatch");
        $finish;
    end

endmodule
